FILE: rtl/mct_pkg.sv
// ----------------------------------------------------------------------------
// mct_pkg
// Shared constants and types for the MIDI controller chase tracker.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int CONTROLLER_COUNT = 128;
    localparam int BANK_SIZE        = 32;

    localparam int CTL_AW = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;
    localparam int CNT_W  = $clog2(CONTROLLER_COUNT + 1);
    localparam int SUM_W  = CNT_W + 8;

    localparam int BANK_COUNT = (CONTROLLER_COUNT + BANK_SIZE - 1) / BANK_SIZE;
    localparam int LAST_BANK  = (BANK_COUNT - 1 > 3) ? 3 : BANK_COUNT - 1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [7:0] KIND_MASK    = 8'hf0;
    localparam logic [7:0] CHANNEL_MASK = 8'h0f;
    localparam logic [7:0] KIND_CONTROL = 8'hb0;
    localparam logic [7:0] KIND_PROGRAM = 8'hc0;
    localparam logic [7:0] KIND_BEND    = 8'he0;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_REPLAY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_PROG,
        ST_BEND,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        SRC_CTL,
        SRC_PROG,
        SRC_BEND
    } t_src;

    typedef struct packed {
        logic load_replay;
        logic step;
        logic rd_en;
        logic push;
        t_src push_src;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic bank_ok;
        logic at_stop;
        logic cur_valid;
        logic last_bank;
        logic prog_valid;
        logic bend_valid;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/mct_ram.sv
// ----------------------------------------------------------------------------
// mct_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mct_ctrl.sv
// ----------------------------------------------------------------------------
// mct_ctrl
// Sequencer for record and replay transfers of the chase tracker.
// ----------------------------------------------------------------------------
module mct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_cmd,
    output logic          o_in_ready,
    input  mct_pkg::t_sts i_sts,
    output mct_pkg::t_cmd o_cmd
);

    mct_pkg::t_state r_state;
    mct_pkg::t_state n_state;
    logic            push_ok;

    assign push_ok = !i_sts.pend_valid || i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.push_src = mct_pkg::SRC_CTL;
        case (r_state)
            mct_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && (i_in_cmd == mct_pkg::CMD_REPLAY) && i_sts.bank_ok) begin
                    o_cmd.load_replay = 1'b1;
                    n_state           = mct_pkg::ST_SCAN;
                end
            end
            mct_pkg::ST_SCAN: begin
                if (i_sts.at_stop) begin
                    n_state = i_sts.last_bank ? mct_pkg::ST_PROG : mct_pkg::ST_FLUSH;
                end else if (i_sts.cur_valid) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = mct_pkg::ST_READ;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            mct_pkg::ST_READ: begin
                if (push_ok) begin
                    o_cmd.push = 1'b1;
                    o_cmd.step = 1'b1;
                    n_state    = mct_pkg::ST_SCAN;
                end
            end
            mct_pkg::ST_PROG: begin
                if (!i_sts.prog_valid) begin
                    n_state = mct_pkg::ST_BEND;
                end else if (push_ok) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_src = mct_pkg::SRC_PROG;
                    n_state        = mct_pkg::ST_BEND;
                end
            end
            mct_pkg::ST_BEND: begin
                if (!i_sts.bend_valid) begin
                    n_state = mct_pkg::ST_FLUSH;
                end else if (push_ok) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_src = mct_pkg::SRC_BEND;
                    n_state        = mct_pkg::ST_FLUSH;
                end
            end
            mct_pkg::ST_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = mct_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = mct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mct_dp.sv
// ----------------------------------------------------------------------------
// mct_dp
// Channel state, controller store, scan pointer and result registers.
// ----------------------------------------------------------------------------
module mct_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_fire,
    input  logic                            i_in_cmd,
    input  logic [mct_pkg::S_TDATA_W-1:0]   i_in_data,
    input  mct_pkg::t_cmd                   i_cmd,
    output mct_pkg::t_sts                   o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mct_pkg::M_TDATA_W-1:0]   o_out_data,
    output logic                            o_out_last
);

    logic [7:0] in_status;
    logic [6:0] in_first;
    logic [6:0] in_second;
    logic [1:0] in_bank;

    assign in_status = i_in_data[7:0];
    assign in_first  = i_in_data[14:8];
    assign in_second = i_in_data[21:15];
    assign in_bank   = i_in_data[23:22];

    logic [mct_pkg::CONTROLLER_COUNT-1:0] r_ctl_valid;
    logic [3:0]                           r_channel;
    logic [6:0]                           r_prog;
    logic                                 r_prog_valid;
    logic [6:0]                           r_bend_lo;
    logic [6:0]                           r_bend_hi;
    logic                                 r_bend_valid;
    logic [mct_pkg::CNT_W-1:0]            r_idx;
    logic [mct_pkg::CNT_W-1:0]            r_stop;
    logic                                 r_last_bank;

    logic [21:0] r_pend;
    logic        r_pend_valid;
    logic        r_out_valid;
    logic [21:0] r_out;
    logic        r_out_last;

    logic        rec;
    logic [7:0]  kind;
    logic        ctl_in_range;
    logic        ctl_write;
    logic [6:0]  ram_rdata;
    logic [mct_pkg::SUM_W-1:0] start_w;
    logic [mct_pkg::SUM_W-1:0] end_w;
    logic [mct_pkg::SUM_W-1:0] stop_w;
    logic [7:0]  chan8;
    logic [21:0] cand;
    logic        out_free;

    assign rec          = i_in_fire && (i_in_cmd == mct_pkg::CMD_RECORD);
    assign kind         = in_status & mct_pkg::KIND_MASK;
    assign ctl_in_range = {1'b0, in_first} < 8'(mct_pkg::CONTROLLER_COUNT);
    assign ctl_write    = rec && (kind == mct_pkg::KIND_CONTROL) && ctl_in_range;

    assign start_w = mct_pkg::SUM_W'(in_bank) * mct_pkg::SUM_W'(mct_pkg::BANK_SIZE);
    assign end_w   = start_w + mct_pkg::SUM_W'(mct_pkg::BANK_SIZE);
    assign stop_w  = (end_w > mct_pkg::SUM_W'(mct_pkg::CONTROLLER_COUNT)) ?
                     mct_pkg::SUM_W'(mct_pkg::CONTROLLER_COUNT) : end_w;

    mct_ram #(
        .WIDTH (7),
        .DEPTH (mct_pkg::CONTROLLER_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ctl_write),
        .i_waddr (in_first[mct_pkg::CTL_AW-1:0]),
        .i_wdata (in_second),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx[mct_pkg::CTL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign chan8 = {4'b0000, r_channel} & mct_pkg::CHANNEL_MASK;

    always_comb begin
        case (i_cmd.push_src)
            mct_pkg::SRC_CTL:  cand = {ram_rdata, 7'(r_idx), mct_pkg::KIND_CONTROL | chan8};
            mct_pkg::SRC_PROG: cand = {7'd0, r_prog, mct_pkg::KIND_PROGRAM | chan8};
            mct_pkg::SRC_BEND: cand = {r_bend_hi, r_bend_lo, mct_pkg::KIND_BEND | chan8};
            default:           cand = '0;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_valid  <= '0;
            r_channel    <= '0;
            r_prog       <= '0;
            r_prog_valid <= 1'b0;
            r_bend_lo    <= '0;
            r_bend_hi    <= '0;
            r_bend_valid <= 1'b0;
        end else if (rec) begin
            r_channel <= in_status[3:0];
            if (kind == mct_pkg::KIND_PROGRAM) begin
                r_prog       <= in_first;
                r_prog_valid <= 1'b1;
            end
            if (kind == mct_pkg::KIND_BEND) begin
                r_bend_lo    <= in_first;
                r_bend_hi    <= in_second;
                r_bend_valid <= 1'b1;
            end
            if (ctl_write) begin
                r_ctl_valid[in_first[mct_pkg::CTL_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_replay) begin
            r_idx       <= mct_pkg::CNT_W'(start_w);
            r_stop      <= mct_pkg::CNT_W'(stop_w);
            r_last_bank <= (in_bank == 2'(mct_pkg::LAST_BANK));
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.push) begin
            r_pend <= cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((i_cmd.push && r_pend_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
                r_out_last  <= i_cmd.flush;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.push && r_pend_valid) || i_cmd.flush) begin
            r_out <= r_pend;
        end
    end

    assign o_sts.bank_ok    = (in_bank <= 2'(mct_pkg::LAST_BANK));
    assign o_sts.at_stop    = (r_idx == r_stop);
    assign o_sts.cur_valid  = r_ctl_valid[r_idx[mct_pkg::CTL_AW-1:0]];
    assign o_sts.last_bank  = r_last_bank;
    assign o_sts.prog_valid = r_prog_valid;
    assign o_sts.bend_valid = r_bend_valid;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {2'b00, r_out};
    assign o_out_last  = r_out_last;

endmodule

FILE: rtl/midi_controller_chase_tracker_unit.sv
// ----------------------------------------------------------------------------
// midi_controller_chase_tracker_unit
// Records MIDI channel state and replays it one controller bank at a time.
// ----------------------------------------------------------------------------
// Input stream: tuser = 0 records the message in tdata (channel, control
// change value, program or pitch bend) and gives nothing back. tuser = 1
// replays the bank in tdata: the bank's controller entries are scanned one
// per cycle, pausing to read each valid one and while the output stalls;
// every valid one adds a control change, and the last bank then adds program
// change and pitch bend when they were recorded. tlast marks the final
// result of a replay; an empty replay sends nothing. The length of a replay
// grows with its valid entries, set by the scan loop over the valid bits and
// the single read port of the value store.
// The first result reaches the output only when a second one is pushed or
// the replay ends, as each result waits in a holding stage until then.
// A stalled output holds its data; the scan waits on it, and input is taken
// again as soon as the final result sits in the output register.
// Reset clears the valid bits, channel, program and bend state and the
// output; controller values need no clearing since they are gated by valid.
// ----------------------------------------------------------------------------
module midi_controller_chase_tracker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // status_byte, data_first, data_second, replay_bank
    input  logic [mct_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_status, out_first, out_second, two zero bits
    output logic [mct_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    mct_pkg::t_cmd cmd;
    mct_pkg::t_sts sts;
    logic          in_ready;
    logic          in_fire;

    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;

    mct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mct_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_in_cmd    (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

FILE: rtl/mct_checker.sv
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks for the chase tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mct_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mct_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mct_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // nothing valid right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // only control change, program change or pitch bend is replayed
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[7:4] == mct_pkg::KIND_CONTROL[7:4]) ||
            (m_axis_tdata[7:4] == mct_pkg::KIND_PROGRAM[7:4]) ||
            (m_axis_tdata[7:4] == mct_pkg::KIND_BEND[7:4]))
        else $error("unexpected message kind");

    // program change carries a zero second byte, padding is zero
    a_prog_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[23:22] == 2'b00) &&
            ((m_axis_tdata[7:4] != mct_pkg::KIND_PROGRAM[7:4]) ||
             (m_axis_tdata[21:15] == 7'd0)))
        else $error("bad second byte or padding");

    // a replay input is never taken while a run is still producing results
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken during a run");

endmodule

bind midi_controller_chase_tracker_unit mct_checker u_mct_checker (.*);
